[hdl/iq_magnitude_phase_averager_unit_defines.svh]
// Assertion macros shared by the magnitude and phase averager RTL.
`ifndef IQ_MAGNITUDE_PHASE_AVERAGER_UNIT_DEFINES_SVH
`define IQ_MAGNITUDE_PHASE_AVERAGER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define IQMPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IQMPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define IQMPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IQMPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define IQMPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define IQMPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/iqmpa_pkg.sv]
// Shared constants and the arctangent table of the magnitude and phase averager.
`timescale 1ns / 1ps
package iqmpa_pkg;

  localparam int IN_W            = 16;
  localparam int MAG_W           = 16;
  localparam int PHASE_W         = 15;
  localparam int MAX_BUNCHES_DEF = 1024;
  localparam int DEF_SUM_W       = IN_W + $clog2(MAX_BUNCHES_DEF);
  localparam int DEF_CNT_W       = $clog2(MAX_BUNCHES_DEF + 1);

  // Sum of two squares of 16-bit values and the digit-by-digit root of it.
  localparam int SQ_W            = 2 * IN_W;

  localparam int GUARD_SHIFT     = 30;
  localparam int CORDIC_STEPS    = 20;
  localparam int STEP_W          = $clog2(CORDIC_STEPS);
  // Angle accumulator in 1/65536 degree.
  localparam int Z_W             = 26;
  localparam int HALF_TURN_DEG   = 180;
  localparam int Z_PER_DEG       = 65536;
  localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(HALF_TURN_DEG * Z_PER_DEG);
  localparam int ROUND_SHIFT     = 10;
  localparam int PHASE_LIMIT     = 11520;

  // atan(2^-step) in degrees, scaled by 65536 and rounded.
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] step);
    logic signed [Z_W-1:0] v;
    case (step)
      STEP_W'(0):  v = Z_W'(2949120);
      STEP_W'(1):  v = Z_W'(1740967);
      STEP_W'(2):  v = Z_W'(919879);
      STEP_W'(3):  v = Z_W'(466945);
      STEP_W'(4):  v = Z_W'(234379);
      STEP_W'(5):  v = Z_W'(117304);
      STEP_W'(6):  v = Z_W'(58666);
      STEP_W'(7):  v = Z_W'(29335);
      STEP_W'(8):  v = Z_W'(14668);
      STEP_W'(9):  v = Z_W'(7334);
      STEP_W'(10): v = Z_W'(3667);
      STEP_W'(11): v = Z_W'(1833);
      STEP_W'(12): v = Z_W'(917);
      STEP_W'(13): v = Z_W'(458);
      STEP_W'(14): v = Z_W'(229);
      STEP_W'(15): v = Z_W'(115);
      STEP_W'(16): v = Z_W'(57);
      STEP_W'(17): v = Z_W'(29);
      STEP_W'(18): v = Z_W'(14);
      STEP_W'(19): v = Z_W'(7);
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/iqmpa_sqrt.sv]
// Iterative rounded square root of I*I + Q*Q, one result bit per cycle.
`timescale 1ns / 1ps
module iqmpa_sqrt (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [iqmpa_pkg::IN_W-1:0]    i_i,
  input  logic signed [iqmpa_pkg::IN_W-1:0]    q_i,
  output logic                                 busy_o,
  output logic        [iqmpa_pkg::MAG_W-1:0]   mag_o
);

  localparam int SQ_W = iqmpa_pkg::SQ_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;

  logic [1:0]             st_q, st_d;
  logic signed [SQ_W-1:0] prod_i, prod_q;
  logic [SQ_W-1:0]        sq_i_q, sq_q_q;
  logic [SQ_W-1:0]        rem_q, root_q, bit_q;
  logic [SQ_W:0]          trial;
  logic                   fits;

  assign prod_i = i_i * i_i;
  assign prod_q = q_i * q_i;
  assign trial  = {1'b0, root_q} + {1'b0, bit_q};
  assign fits   = {1'b0, rem_q} >= trial;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (start_i) begin
        st_d = ST_SUM;
      end
      ST_SUM:  st_d = ST_ITER;
      ST_ITER: if (bit_q[0]) begin
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && start_i) begin
      sq_i_q <= $unsigned(prod_i);
      sq_q_q <= $unsigned(prod_q);
    end
    if (st_q == ST_SUM) begin
      rem_q  <= sq_i_q + sq_q_q;
      root_q <= '0;
      bit_q  <= SQ_W'(1) << (SQ_W - 2);
    end
    if (st_q == ST_ITER) begin
      if (fits) begin
        rem_q  <= rem_q - trial[SQ_W-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // The remainder is n - r*r; the root rounds up when n > r*r + r.
  assign mag_o  = iqmpa_pkg::MAG_W'(root_q + SQ_W'(rem_q > root_q));
  assign busy_o = st_q != ST_IDLE;

endmodule

[hdl/iqmpa_cordic.sv]
// Iterative CORDIC vectoring unit that returns the phase in 1/64 degree.
`timescale 1ns / 1ps
module iqmpa_cordic #(
  parameter int OP_W = iqmpa_pkg::DEF_SUM_W + 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [OP_W-1:0]                x_i,
  input  logic signed [OP_W-1:0]                y_i,
  output logic                                  busy_o,
  output logic signed [iqmpa_pkg::PHASE_W-1:0]  phase_o
);

  localparam int CW     = OP_W + iqmpa_pkg::GUARD_SHIFT + 2;
  localparam int Z_W    = iqmpa_pkg::Z_W;
  localparam int STEP_W = iqmpa_pkg::STEP_W;
  localparam logic [Z_W-1:0] HALF_LSB = Z_W'(1) << (iqmpa_pkg::ROUND_SHIFT - 1);

  logic                  run_q;
  logic [STEP_W-1:0]     step_q;
  logic signed [CW-1:0]  x_q, y_q, x_ext, y_ext, dx, dy;
  logic signed [Z_W-1:0] z_q;
  logic                  y_pos, y_neg, last_step;
  logic                  z_neg;
  logic [Z_W-1:0]        z_abs, z_rnd, z_lim;

  assign x_ext     = CW'(x_i) <<< iqmpa_pkg::GUARD_SHIFT;
  assign y_ext     = CW'(y_i) <<< iqmpa_pkg::GUARD_SHIFT;
  assign dx        = y_q >>> step_q;
  assign dy        = x_q >>> step_q;
  assign y_neg     = y_q[CW-1];
  assign y_pos     = !y_q[CW-1] && (y_q != '0);
  assign last_step = step_q == STEP_W'(iqmpa_pkg::CORDIC_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else if (!run_q && start_i) begin
      run_q  <= 1'b1;
      step_q <= '0;
    end else if (run_q) begin
      run_q  <= !last_step;
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!run_q && start_i) begin
      // Vectors in the left half plane are turned by half a turn first.
      if (x_i[OP_W-1]) begin
        x_q <= -x_ext;
        y_q <= -y_ext;
        z_q <= y_i[OP_W-1] ? -iqmpa_pkg::HALF_TURN_Z : iqmpa_pkg::HALF_TURN_Z;
      end else begin
        x_q <= x_ext;
        y_q <= y_ext;
        z_q <= '0;
      end
    end else if (run_q) begin
      if (y_pos) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + iqmpa_pkg::atan_entry(step_q);
      end else if (y_neg) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - iqmpa_pkg::atan_entry(step_q);
      end
    end
  end

  // Round to 1/64 degree with halves away from zero, then clamp.
  assign z_neg   = z_q[Z_W-1];
  assign z_abs   = z_neg ? $unsigned(-z_q) : $unsigned(z_q);
  assign z_rnd   = (z_abs + HALF_LSB) >> iqmpa_pkg::ROUND_SHIFT;
  assign z_lim   = (z_rnd > Z_W'(iqmpa_pkg::PHASE_LIMIT)) ? Z_W'(iqmpa_pkg::PHASE_LIMIT) : z_rnd;
  assign phase_o = z_neg ? -$signed(iqmpa_pkg::PHASE_W'(z_lim))
                         : $signed(iqmpa_pkg::PHASE_W'(z_lim));
  assign busy_o  = run_q;

endmodule

[hdl/iqmpa_div.sv]
// Restoring divider for the mean magnitude, one quotient bit per cycle.
`timescale 1ns / 1ps
module iqmpa_div #(
  parameter int NUM_W = iqmpa_pkg::DEF_SUM_W,
  parameter int DEN_W = iqmpa_pkg::DEF_CNT_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [NUM_W-1:0]                   num_i,
  input  logic [DEN_W-1:0]                   den_i,
  output logic                               busy_o,
  output logic [iqmpa_pkg::MAG_W-1:0]        quo_o
);

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [ITER_W-1:0] iter_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [DEN_W:0]    shifted;
  logic              take;

  // The dividend register fills with quotient bits from the bottom.
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign take    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (iter_q == '0 && start_i) begin
      iter_q <= ITER_W'(NUM_W);
    end else if (iter_q != '0) begin
      iter_q <= iter_q - ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (iter_q == '0 && start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (iter_q != '0) begin
      rem_q <= take ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], take};
    end
  end

  assign quo_o  = num_q[iqmpa_pkg::MAG_W-1:0];
  assign busy_o = iter_q != '0;

endmodule

[hdl/iq_magnitude_phase_averager_unit.sv]
// Top level of the bunch magnitude and phase averager with its turn accumulators.
// An accepted transaction reaches out_valid_o once the square root and the 20-step CORDIC are done.
// On the last bunch of a turn the divider adds 16 + log2(MAX_BUNCHES) steps.
// A new transaction is accepted only after the previous result is loaded into the output register.
// The output register holds a result while the next transaction is already accepted.
// Reset clears the sums, the bunch count and the threshold at once; no clearing pass.
`timescale 1ns / 1ps
`include "iq_magnitude_phase_averager_unit_defines.svh"
module iq_magnitude_phase_averager_unit #(
  parameter int MAX_BUNCHES = iqmpa_pkg::MAX_BUNCHES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [iqmpa_pkg::MAG_W-1:0]    cfg_magnitude_threshold_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [iqmpa_pkg::IN_W-1:0]     mean_i_i,
  input  logic signed [iqmpa_pkg::IN_W-1:0]     mean_q_i,
  input  logic                                  last_bunch_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [iqmpa_pkg::MAG_W-1:0]    magnitude_o,
  output logic signed [iqmpa_pkg::PHASE_W-1:0]  bunch_phase_o,
  output logic                                  above_threshold_o,
  output logic                                  end_of_turn_o,
  output logic        [iqmpa_pkg::MAG_W-1:0]    turn_magnitude_o,
  output logic signed [iqmpa_pkg::PHASE_W-1:0]  turn_phase_o
);

  localparam int IN_W    = iqmpa_pkg::IN_W;
  localparam int MAG_W   = iqmpa_pkg::MAG_W;
  localparam int PHASE_W = iqmpa_pkg::PHASE_W;
  localparam int CNT_W   = $clog2(MAX_BUNCHES + 1);
  localparam int SUM_W   = IN_W + $clog2(MAX_BUNCHES);
  localparam int OP_W    = SUM_W + 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ITEM    = 3'd1;
  localparam logic [2:0] ST_MEAN_GO = 3'd2;
  localparam logic [2:0] ST_MEAN    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [MAG_W-1:0]        thr_q, thr_d;
  logic [SUM_W-1:0]        mag_sum_q, mag_sum_d;
  logic signed [SUM_W-1:0] i_sum_q, i_sum_d, q_sum_q, q_sum_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;
  logic                    out_valid_q, out_valid_d;

  logic signed [IN_W-1:0]  item_i_q, item_q_q;
  logic                    last_q;
  logic [MAG_W-1:0]        mag_q, mmag_q, out_mag_q, out_mmag_q;
  logic signed [PHASE_W-1:0] ph_q, mph_q, out_ph_q, out_mph_q;
  logic                    above_q, end_q, out_above_q, out_end_q;

  logic                    in_accept, item_done, mean_done, load_out;
  logic                    above, turn_end;
  logic                    sqrt_busy, cordic_busy, div_busy, cordic_start;
  logic [MAG_W-1:0]        sqrt_mag, div_quo;
  logic signed [OP_W-1:0]  cordic_x, cordic_y;
  logic signed [PHASE_W-1:0] cordic_phase;

  assign in_ready_o  = state_q == ST_IDLE;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign item_done = (state_q == ST_ITEM) && !sqrt_busy && !cordic_busy;
  assign mean_done = (state_q == ST_MEAN) && !div_busy && !cordic_busy;
  assign above     = sqrt_mag > thr_q;
  assign cnt_inc   = cnt_q + CNT_W'(1);
  // A full count ends the turn even without the last-bunch flag.
  assign turn_end  = last_q || (cnt_inc >= CNT_W'(MAX_BUNCHES));

  // The bunch phase uses the input ports at acceptance; the mean phase uses the sums.
  assign cordic_start = in_accept || (state_q == ST_MEAN_GO);
  assign cordic_x = (state_q == ST_IDLE) ? OP_W'(mean_q_i) : OP_W'(q_sum_q);
  assign cordic_y = (state_q == ST_IDLE) ? -OP_W'(mean_i_i) : -OP_W'(i_sum_q);

  iqmpa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .i_i     (mean_i_i),
    .q_i     (mean_q_i),
    .busy_o  (sqrt_busy),
    .mag_o   (sqrt_mag)
  );

  iqmpa_cordic #(
    .OP_W (OP_W)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .x_i     (cordic_x),
    .y_i     (cordic_y),
    .busy_o  (cordic_busy),
    .phase_o (cordic_phase)
  );

  iqmpa_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_MEAN_GO),
    .num_i   (mag_sum_q),
    .den_i   (cnt_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    thr_d       = cfg_valid_i ? cfg_magnitude_threshold_i : thr_q;
    mag_sum_d   = mag_sum_q;
    i_sum_d     = i_sum_q;
    q_sum_d     = q_sum_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    load_out    = 1'b0;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        state_d = ST_ITEM;
      end
      ST_ITEM: if (item_done) begin
        if (above) begin
          i_sum_d = i_sum_q + SUM_W'(item_i_q);
          q_sum_d = q_sum_q + SUM_W'(item_q_q);
        end
        mag_sum_d = mag_sum_q + SUM_W'(sqrt_mag);
        cnt_d     = cnt_inc;
        state_d   = turn_end ? ST_MEAN_GO : ST_DONE;
      end
      ST_MEAN_GO: begin
        // The divider and the CORDIC took their operands at this edge.
        mag_sum_d = '0;
        i_sum_d   = '0;
        q_sum_d   = '0;
        cnt_d     = '0;
        state_d   = ST_MEAN;
      end
      ST_MEAN: if (mean_done) begin
        state_d = ST_DONE;
      end
      ST_DONE: if (!out_valid_q || out_ready_i) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= '0;
      mag_sum_q   <= '0;
      i_sum_q     <= '0;
      q_sum_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      mag_sum_q   <= mag_sum_d;
      i_sum_q     <= i_sum_d;
      q_sum_q     <= q_sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_i_q <= mean_i_i;
      item_q_q <= mean_q_i;
      last_q   <= last_bunch_i;
    end
    if (item_done) begin
      mag_q   <= sqrt_mag;
      above_q <= above;
      ph_q    <= above ? cordic_phase : '0;
      end_q   <= turn_end;
      mmag_q  <= '0;
      mph_q   <= '0;
    end
    if (mean_done) begin
      mmag_q <= div_quo;
      mph_q  <= cordic_phase;
    end
    if (load_out) begin
      out_mag_q   <= mag_q;
      out_ph_q    <= ph_q;
      out_above_q <= above_q;
      out_end_q   <= end_q;
      out_mmag_q  <= mmag_q;
      out_mph_q   <= mph_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign magnitude_o       = out_mag_q;
  assign bunch_phase_o     = out_ph_q;
  assign above_threshold_o = out_above_q;
  assign end_of_turn_o     = out_end_q;
  assign turn_magnitude_o  = out_mmag_q;
  assign turn_phase_o      = out_mph_q;

  `IQMPA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "block still ready after accepting a transaction")
  `IQMPA_ASSERT_IMP(a_count_below_max, clk_i, rst_ni, state_q != ST_MEAN_GO, cnt_q < CNT_W'(MAX_BUNCHES), "bunch count reached the turn limit without ending the turn")
  `IQMPA_ASSERT_NEXT(a_turn_clears, clk_i, rst_ni, state_q == ST_MEAN_GO, cnt_q == '0 && mag_sum_q == '0 && i_sum_q == '0 && q_sum_q == '0, "turn accumulators not cleared")
  `IQMPA_ASSERT_IMP(a_mean_only_at_end, clk_i, rst_ni, out_valid_o && !end_of_turn_o, turn_magnitude_o == '0 && turn_phase_o == '0, "mean fields set outside the end of a turn")
  `IQMPA_ASSERT_IMP(a_phase_needs_above, clk_i, rst_ni, out_valid_o && !above_threshold_o, bunch_phase_o == '0, "bunch phase set below the threshold")

endmodule

[test/tb.sv]
// Bunch magnitude and phase averager testbench: directed and random traffic checked by a predictor.
`timescale 1ns / 1ps
module tb;

  localparam int IN_W            = iqmpa_pkg::IN_W;
  localparam int MAG_W           = iqmpa_pkg::MAG_W;
  localparam int PHASE_W         = iqmpa_pkg::PHASE_W;
  localparam int CORDIC_STEPS    = iqmpa_pkg::CORDIC_STEPS;
  localparam int GUARD_SHIFT     = iqmpa_pkg::GUARD_SHIFT;
  localparam int PHASE_LIMIT     = iqmpa_pkg::PHASE_LIMIT;
  localparam int MAX_BUNCHES_DEF = iqmpa_pkg::MAX_BUNCHES_DEF;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic        [MAG_W-1:0]   magnitude;
    logic signed [PHASE_W-1:0] bunch_phase;
    logic                      above_threshold;
    logic                      end_of_turn;
    logic        [MAG_W-1:0]   turn_magnitude;
    logic signed [PHASE_W-1:0] turn_phase;
  } bunch_result_t;

  // Predicts the result of every accepted bunch and checks the results in order.
  class turn_scoreboard;
    bunch_result_t     pending[$];
    logic [MAG_W-1:0]  threshold = '0;
    longint            magnitude_sum = 0;
    longint            in_phase_sum = 0;
    longint            quadrature_sum = 0;
    longint            bunch_count = 0;
    int                errors = 0;
    longint            atan_step_z[CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    function longint unsigned rounded_root(longint unsigned n);
      longint unsigned root, probe, rem;
      root = 0;
      probe = 64'd1 << 62;
      rem = n;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem -= root + probe;
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      if (rem > root) root++;
      return root;
    endfunction

    // Vectoring CORDIC on (x, y), result in 1/64 degree.
    function longint vector_phase(longint xin, longint yin);
      longint x, y, z, dx, dy, r;
      x = xin * (64'sd1 << GUARD_SHIFT);
      y = yin * (64'sd1 << GUARD_SHIFT);
      z = 0;
      if (xin == 0 && yin == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 64'sd180 * 65536 : -64'sd180 * 65536;
        x = -x;
        y = -y;
      end
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y > 0) begin
          x += dx;
          y -= dy;
          z += atan_step_z[k];
        end else if (y < 0) begin
          x -= dx;
          y += dy;
          z -= atan_step_z[k];
        end
      end
      r = (z >= 0) ? (z + 512) / 1024 : -((-z + 512) / 1024);
      if (r > PHASE_LIMIT) r = PHASE_LIMIT;
      if (r < -PHASE_LIMIT) r = -PHASE_LIMIT;
      return r;
    endfunction

    function void note_input(logic signed [IN_W-1:0] i_in, logic signed [IN_W-1:0] q_in,
                             logic last);
      longint iv, qv;
      longint unsigned mag;
      bunch_result_t e;
      iv = i_in;
      qv = q_in;
      mag = rounded_root(longint'(iv * iv + qv * qv));
      e.magnitude = MAG_W'(mag);
      e.above_threshold = (mag > threshold);
      e.bunch_phase = '0;
      e.turn_magnitude = '0;
      e.turn_phase = '0;
      if (e.above_threshold) begin
        e.bunch_phase = PHASE_W'(vector_phase(qv, -iv));
        in_phase_sum += iv;
        quadrature_sum += qv;
      end
      magnitude_sum += longint'(mag);
      bunch_count++;
      // A turn that runs to the bunch limit closes on its own.
      e.end_of_turn = last || (bunch_count >= MAX_BUNCHES_DEF);
      if (e.end_of_turn) begin
        e.turn_magnitude = MAG_W'(magnitude_sum / bunch_count);
        e.turn_phase = PHASE_W'(vector_phase(quadrature_sum, -in_phase_sum));
        magnitude_sum = 0;
        in_phase_sum = 0;
        quadrature_sum = 0;
        bunch_count = 0;
      end
      pending.push_back(e);
    endfunction

    function void compare_field(string name, longint expected, longint actual);
      if (expected != actual) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
        errors++;
      end
    endfunction

    function void check_result(bunch_result_t got);
      bunch_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with no transaction outstanding, magnitude %0d",
                 $time, got.magnitude);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("magnitude", e.magnitude, got.magnitude);
      compare_field("bunch_phase", e.bunch_phase, got.bunch_phase);
      compare_field("above_threshold", e.above_threshold, got.above_threshold);
      compare_field("end_of_turn", e.end_of_turn, got.end_of_turn);
      compare_field("turn_magnitude", e.turn_magnitude, got.turn_magnitude);
      compare_field("turn_phase", e.turn_phase, got.turn_phase);
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic        [MAG_W-1:0]   cfg_magnitude_threshold_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [IN_W-1:0]    mean_i_i;
  logic signed [IN_W-1:0]    mean_q_i;
  logic                      last_bunch_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic        [MAG_W-1:0]   magnitude_o;
  logic signed [PHASE_W-1:0] bunch_phase_o;
  logic                      above_threshold_o;
  logic                      end_of_turn_o;
  logic        [MAG_W-1:0]   turn_magnitude_o;
  logic signed [PHASE_W-1:0] turn_phase_o;

  turn_scoreboard sb = new;
  bit             no_idling = 1'b0;
  int             idle_cycles = 0;

  iq_magnitude_phase_averager_unit dut (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cfg_valid_i               (cfg_valid_i),
    .cfg_ready_o               (cfg_ready_o),
    .cfg_magnitude_threshold_i (cfg_magnitude_threshold_i),
    .in_valid_i                (in_valid_i),
    .in_ready_o                (in_ready_o),
    .mean_i_i                  (mean_i_i),
    .mean_q_i                  (mean_q_i),
    .last_bunch_i              (last_bunch_i),
    .out_valid_o               (out_valid_o),
    .out_ready_i               (out_ready_i),
    .magnitude_o               (magnitude_o),
    .bunch_phase_o             (bunch_phase_o),
    .above_threshold_o         (above_threshold_o),
    .end_of_turn_o             (end_of_turn_o),
    .turn_magnitude_o          (turn_magnitude_o),
    .turn_phase_o              (turn_phase_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Monitors: transactions are taken from the values present just before the edge.
  always @(posedge clk_i) begin
    bunch_result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.threshold = cfg_magnitude_threshold_i;
      if (in_valid_i && in_ready_o) sb.note_input(mean_i_i, mean_q_i, last_bunch_i);
      if (out_valid_o && out_ready_i) begin
        got.magnitude = magnitude_o;
        got.bunch_phase = bunch_phase_o;
        got.above_threshold = above_threshold_o;
        got.end_of_turn = end_of_turn_o;
        got.turn_magnitude = turn_magnitude_o;
        got.turn_phase = turn_phase_o;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Result side backpressure: mostly short stalls, now and then a long one.
  initial begin
    int hold_left;
    int pick;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (no_idling) begin
        out_ready_i <= 1'b1;
        hold_left = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_ready_i <= 1'b1;
          hold_left = $urandom_range(0, 8);
        end else if (pick < 85) begin
          out_ready_i <= 1'b0;
          hold_left = $urandom_range(0, 2);
        end else if (pick < 95) begin
          out_ready_i <= 1'b0;
          hold_left = $urandom_range(3, 8);
        end else begin
          out_ready_i <= 1'b0;
          hold_left = $urandom_range(20, 40);
        end
      end
    end
  end

  function automatic int gap_cycles();
    int pick;
    if (no_idling) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_bunch(logic signed [IN_W-1:0] i_val, logic signed [IN_W-1:0] q_val,
                            logic last);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mean_i_i <= i_val;
    mean_q_i <= q_val;
    last_bunch_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Only issued while the block holds no outstanding transaction.
  task automatic write_threshold(logic [MAG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_magnitude_threshold_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_component(output logic signed [IN_W-1:0] v);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      v = IN_W'($urandom());
    end else if (pick < 70) begin
      v = IN_W'($urandom_range(0, 128)) - IN_W'(64);
    end else if (pick < 80) begin
      v = '0;
    end else begin
      case ($urandom_range(0, 5))
        0: v = -16'sd32768;
        1: v = -16'sd32767;
        2: v = -16'sd1;
        3: v = 16'sd1;
        4: v = 16'sd32767;
        default: v = IN_W'($urandom_range(0, 2000)) + IN_W'(20000);
      endcase
    end
  endtask

  task automatic send_random_bunch(bit allow_last);
    logic signed [IN_W-1:0] i_val, q_val;
    logic last;
    random_component(i_val);
    random_component(q_val);
    last = allow_last && ($urandom_range(0, 11) == 0);
    send_bunch(i_val, q_val, last);
  endtask

  initial begin
    logic [MAG_W-1:0] phase_threshold[6];
    phase_threshold = '{16'd0, 16'd46341, 16'd1000, 16'd20000, 16'd30000, 16'd0};
    phase_threshold[5] = MAG_W'($urandom_range(0, 46341));
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_magnitude_threshold_i = '0;
    in_valid_i = 1'b0;
    mean_i_i = '0;
    mean_q_i = '0;
    last_bunch_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_threshold(16'd0);
    // Zero vector alone in a turn: no phase, zero mean.
    send_bunch(16'sd0, 16'sd0, 1'b1);
    send_bunch(-16'sd32768, -16'sd32768, 1'b0);
    send_bunch(16'sd32767, 16'sd32767, 1'b0);
    send_bunch(-16'sd32768, 16'sd32767, 1'b0);
    send_bunch(16'sd32767, -16'sd32768, 1'b1);
    // Zero I with negative Q lands on +180 degrees, for the bunch and the mean.
    send_bunch(16'sd0, -16'sd100, 1'b1);
    send_bunch(16'sd0, -16'sd32768, 1'b0);
    send_bunch(16'sd1, -16'sd32768, 1'b1);
    send_bunch(-16'sd1, -16'sd32768, 1'b1);
    // Opposite vectors cancel, so the summed vector is zero.
    send_bunch(16'sd5, 16'sd3, 1'b0);
    send_bunch(-16'sd5, -16'sd3, 1'b1);
    send_bunch(16'sd32767, 16'sd0, 1'b0);
    send_bunch(-16'sd32768, 16'sd0, 1'b0);
    send_bunch(16'sd0, 16'sd32767, 1'b1);
    send_bunch(16'sd1, 16'sd0, 1'b0);
    send_bunch(16'sd0, 16'sd1, 1'b0);
    send_bunch(-16'sd1, -16'sd1, 1'b1);
    send_bunch(16'sd100, -16'sd1, 1'b0);
    send_bunch(-16'sd100, 16'sd1, 1'b0);
    send_bunch(16'sd3, 16'sd4, 1'b1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_threshold(phase_threshold[p]);
      no_idling = (p == 2);
      repeat (105) send_random_bunch(1'b1);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.pending.size());
      $display("tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/iqmpa_pkg.sv
hdl/iqmpa_sqrt.sv
hdl/iqmpa_cordic.sv
hdl/iqmpa_div.sv
hdl/iq_magnitude_phase_averager_unit.sv
test/tb.sv
